>>> sv/acrb_pkg.sv
// Shared constants, types and state codes for the circle/rectangle blender.
`timescale 1ns / 1ps
package acrb_pkg;

  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 256;
  localparam int FRAME_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW           = $clog2(FRAME_DEPTH);

  localparam int COLOR_W  = 24;
  localparam int POS_W    = 18;
  localparam int RAD_W    = 16;
  localparam int SIZE_W   = 10;
  localparam int ALPHA_W  = 9;
  localparam int ACTIVE_W = 9;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // pixel coordinates, signed
  localparam int CW    = 14;
  // circle bound arithmetic, Q.8 signed
  localparam int EW    = 21;
  // distance from pixel center, Q.8 signed
  localparam int DXW   = 23;
  // shared multiplier operands and product
  localparam int MAW   = 34;
  localparam int MBW   = 21;
  localparam int PW    = MAW + MBW;
  localparam int RADQ_W = RAD_W + 1;
  localparam int O2W   = 34;
  localparam int D2W   = 2 * MBW + 1;
  localparam int NW    = 44;
  localparam int QW    = 9;
  localparam int QSTEP_W = 4;

  localparam int RING_Q8 = 166;
  localparam int HALF_Q8 = 128;
  localparam int ONE_Q8  = 256;

  localparam logic [PADDR_W-1:0] ADDR_ACTIVE_W = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_ACTIVE_H = 3'd4;

  typedef enum logic [1:0] {
    FUNC_CIRCLE = 2'd0,
    FUNC_RECT   = 2'd1,
    FUNC_WRITE  = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_C_O2,
    ST_C_I2,
    ST_C_DEN,
    ST_P_DX,
    ST_P_DY,
    ST_P_D2,
    ST_P_TST,
    ST_P_NUM,
    ST_P_DIV,
    ST_P_RD,
    ST_P_WR,
    ST_DONE
  } state_e;

endpackage

>>> sv/acrb_ifs.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface acrb_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic signed [acrb_pkg::POS_W-1:0] pos_x;
  logic signed [acrb_pkg::POS_W-1:0] pos_y;
  logic [acrb_pkg::RAD_W-1:0]        radius;
  logic [acrb_pkg::SIZE_W-1:0]       rect_width;
  logic [acrb_pkg::SIZE_W-1:0]       rect_height;
  logic [acrb_pkg::COLOR_W-1:0]      color;
  logic [acrb_pkg::ALPHA_W-1:0]      alpha;

  modport source (output valid, func, pos_x, pos_y, radius, rect_width, rect_height,
                  color, alpha, input ready);
  modport sink (input valid, func, pos_x, pos_y, radius, rect_width, rect_height,
                color, alpha, output ready);
endinterface

interface acrb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [acrb_pkg::COLOR_W-1:0] pixel_color;
  logic                         finished;

  modport source (output valid, pixel_color, finished, input ready);
  modport sink (input valid, pixel_color, finished, output ready);
endinterface

>>> sv/acrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module acrb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/acrb_mul.sv
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
module acrb_mul (
  input  logic                    clk_i,
  input  logic [acrb_pkg::MAW-1:0] a_i,
  input  logic [acrb_pkg::MBW-1:0] b_i,
  output logic [acrb_pkg::PW-1:0]  prod_o
);

  logic [acrb_pkg::PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= acrb_pkg::PW'(a_i) * acrb_pkg::PW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> sv/acrb_div.sv
// Restoring divider, one quotient bit per cycle, for ring coverage.
`timescale 1ns / 1ps
module acrb_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [acrb_pkg::NW-1:0]  num_i,
  input  logic [acrb_pkg::O2W-1:0] den_i,
  output logic                     done_o,
  output logic [acrb_pkg::QW-1:0]  quo_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [acrb_pkg::QSTEP_W-1:0] step_q, step_d;
  logic [acrb_pkg::NW-1:0]      rem_q, rem_d;
  logic [acrb_pkg::O2W-1:0]     den_q, den_d;
  logic [acrb_pkg::QW-1:0]      quo_q, quo_d;
  logic [acrb_pkg::NW-1:0]      shifted;

  // quotient never exceeds 511, so 9 steps from bit 8 down
  assign shifted = acrb_pkg::NW'(den_q) << step_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = acrb_pkg::QSTEP_W'(acrb_pkg::QW - 1);
      rem_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      if (rem_q >= shifted) begin
        rem_d = rem_q - shifted;
        quo_d = quo_q | (acrb_pkg::QW'(1) << step_q);
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> sv/acrb_blend.sv
// Per-channel alpha blend with rounding.
`timescale 1ns / 1ps
module acrb_blend (
  input  logic [acrb_pkg::COLOR_W-1:0] dst_i,
  input  logic [acrb_pkg::COLOR_W-1:0] src_i,
  input  logic [acrb_pkg::ALPHA_W-1:0] alpha_i,
  output logic [acrb_pkg::COLOR_W-1:0] res_o
);

  logic [acrb_pkg::ALPHA_W-1:0] inv;
  logic [17:0]                  acc [3];

  assign inv = acrb_pkg::ALPHA_W'(acrb_pkg::ONE_Q8) - alpha_i;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = 18'(dst_i[8*c +: 8]) * 18'(inv) + 18'(src_i[8*c +: 8]) * 18'(alpha_i)
               + 18'(acrb_pkg::HALF_Q8);
      res_o[8*c +: 8] = acc[c][15:8];
    end
  end

endmodule

>>> sv/antialiased_circle_rect_blender.sv
// Top level: command sequencer, configuration registers and frame store.
//
//  channel | dir | handshake        | content
//  req     | in  | valid/ready      | func, pos_x, pos_y, radius, rect size, color, alpha
//  rsp     | out | valid/ready      | pixel_color, finished
//  apb     | in  | psel/penable     | active_width (0x0), active_height (0x4)
//
// Write pixel: IDLE only; read pixel: READ. Rectangle: RD, WR per clipped pixel.
// Circle: setup C_O2, C_I2, C_DEN, then per box pixel P_DX, P_DY, P_D2, P_TST;
// outside ones end there, inner go to P_WR, ring via P_NUM, P_DIV (9-step), P_WR.
// No request is taken while a command runs; a finished response waits in its
// register and the next request is accepted meanwhile. Frame store is not cleared.
`timescale 1ns / 1ps
module antialiased_circle_rect_blender (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  acrb_req_if.sink                        req,
  acrb_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [acrb_pkg::PADDR_W-1:0]    paddr,
  input  logic [acrb_pkg::PDATA_W-1:0]    pwdata,
  output logic [acrb_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  localparam int CW  = acrb_pkg::CW;
  localparam int EW  = acrb_pkg::EW;
  localparam int DXW = acrb_pkg::DXW;
  localparam int AW  = acrb_pkg::AW;

  acrb_pkg::state_e state_q, state_d;

  logic [acrb_pkg::ACTIVE_W-1:0] active_w_q, active_h_q;
  logic                          rsp_valid_q;
  logic [acrb_pkg::COLOR_W-1:0]  rsp_pix_q;

  // command registers
  logic signed [acrb_pkg::POS_W-1:0] cx_q, cy_q;
  logic [acrb_pkg::RADQ_W-1:0]       outer_q, inner_q;
  logic [acrb_pkg::COLOR_W-1:0]      color_q, pix_q;
  logic [acrb_pkg::ALPHA_W-1:0]      a_q, eff_q;
  logic signed [CW-1:0]              x_lo_q, x_hi_q, y_hi_q, cur_x_q, cur_y_q;
  logic                              circ_q, rd_ok_q;
  logic [acrb_pkg::O2W-1:0]          o2_q, i2_q, den_q;
  logic [acrb_pkg::D2W-1:0]          d2_q;

  logic                  accept, can_load, last_pix, advance;
  acrb_pkg::func_e       func_in;
  logic [acrb_pkg::ALPHA_W-1:0] a_sat;
  logic signed [CW-1:0]  vis_w, vis_h, ix, iy;
  logic signed [CW-1:0]  x_lo, x_hi, y_lo, y_hi;
  logic signed [EW-1:0]  cxm, cxp, cym, cyp;
  logic                  pix_inside, draw_none;
  logic [acrb_pkg::RADQ_W-1:0] outer_in, inner_in;
  logic signed [DXW-1:0] dx, dy;
  logic [acrb_pkg::MBW-1:0] adx, ady;
  logic                  d2_out, d2_in;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         addr_in, addr_cur, ram_addr;
  logic [acrb_pkg::COLOR_W-1:0] ram_wdata, ram_rdata, blend_res;

  logic [acrb_pkg::MAW-1:0] mul_a;
  logic [acrb_pkg::MBW-1:0] mul_b;
  logic [acrb_pkg::PW-1:0]  prod;
  logic                     div_start, div_done;
  logic [acrb_pkg::NW-1:0]  div_num;
  logic [acrb_pkg::QW-1:0]  div_quo;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_comb begin
    case (paddr)
      acrb_pkg::ADDR_ACTIVE_W: prdata = acrb_pkg::PDATA_W'(active_w_q);
      acrb_pkg::ADDR_ACTIVE_H: prdata = acrb_pkg::PDATA_W'(active_h_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_w_q <= acrb_pkg::ACTIVE_W'(acrb_pkg::ONE_Q8);
      active_h_q <= acrb_pkg::ACTIVE_W'(acrb_pkg::ONE_Q8);
    end else if (psel && penable && pwrite) begin
      if (paddr == acrb_pkg::ADDR_ACTIVE_W) begin
        active_w_q <= pwdata[acrb_pkg::ACTIVE_W-1:0];
      end
      if (paddr == acrb_pkg::ADDR_ACTIVE_H) begin
        active_h_q <= pwdata[acrb_pkg::ACTIVE_W-1:0];
      end
    end
  end

  // ---------------- command decode ----------------
  assign accept  = req.valid && req.ready;
  assign func_in = acrb_pkg::func_e'(req.func);
  assign a_sat   = req.alpha[acrb_pkg::ALPHA_W-1] ?
                   acrb_pkg::ALPHA_W'(acrb_pkg::ONE_Q8) : req.alpha;

  always_comb begin
    if (int'(active_w_q) > acrb_pkg::FRAME_WIDTH) vis_w = CW'(acrb_pkg::FRAME_WIDTH);
    else vis_w = CW'(signed'({1'b0, active_w_q}));
    if (int'(active_h_q) > acrb_pkg::FRAME_HEIGHT) vis_h = CW'(acrb_pkg::FRAME_HEIGHT);
    else vis_h = CW'(signed'({1'b0, active_h_q}));
  end

  assign ix = CW'(req.pos_x >>> 8);
  assign iy = CW'(req.pos_y >>> 8);
  assign pix_inside = (ix >= 0) && (iy >= 0) && (ix < vis_w) && (iy < vis_h);

  assign outer_in = acrb_pkg::RADQ_W'(req.radius) + acrb_pkg::RADQ_W'(acrb_pkg::RING_Q8);
  assign inner_in = (int'(req.radius) > acrb_pkg::RING_Q8) ?
                    acrb_pkg::RADQ_W'(req.radius) - acrb_pkg::RADQ_W'(acrb_pkg::RING_Q8) :
                    '0;

  // floor(c-r-1) and ceil(c+r+1) in pixels
  assign cxm = EW'(req.pos_x) - EW'(signed'({1'b0, req.radius})) - EW'(acrb_pkg::ONE_Q8);
  assign cxp = EW'(req.pos_x) + EW'(signed'({1'b0, req.radius}))
               + EW'(acrb_pkg::ONE_Q8 + 255);
  assign cym = EW'(req.pos_y) - EW'(signed'({1'b0, req.radius})) - EW'(acrb_pkg::ONE_Q8);
  assign cyp = EW'(req.pos_y) + EW'(signed'({1'b0, req.radius}))
               + EW'(acrb_pkg::ONE_Q8 + 255);

  always_comb begin
    logic signed [CW-1:0] lx, hx, ly, hy;
    if (func_in == acrb_pkg::FUNC_CIRCLE) begin
      lx = CW'(cxm >>> 8);
      hx = CW'(cxp >>> 8);
      ly = CW'(cym >>> 8);
      hy = CW'(cyp >>> 8);
      x_lo = (lx < 0) ? '0 : lx;
      y_lo = (ly < 0) ? '0 : ly;
      x_hi = (hx > vis_w - 1) ? vis_w - 1 : hx;
      y_hi = (hy > vis_h - 1) ? vis_h - 1 : hy;
    end else begin
      lx = ix + CW'(signed'({1'b0, req.rect_width}));
      ly = iy + CW'(signed'({1'b0, req.rect_height}));
      hx = (lx > vis_w) ? vis_w : lx;
      hy = (ly > vis_h) ? vis_h : ly;
      x_lo = (ix < 0) ? '0 : ix;
      y_lo = (iy < 0) ? '0 : iy;
      x_hi = hx - 1;
      y_hi = hy - 1;
    end
  end

  always_comb begin
    draw_none = (a_sat == '0) || (x_lo > x_hi) || (y_lo > y_hi);
    if (func_in == acrb_pkg::FUNC_CIRCLE) begin
      draw_none = draw_none || (req.radius == '0);
    end else begin
      draw_none = draw_none || (req.rect_width == '0) || (req.rect_height == '0);
    end
  end

  // ---------------- pixel walk ----------------
  assign last_pix = (cur_x_q == x_hi_q) && (cur_y_q == y_hi_q);

  assign dx  = (DXW'(cur_x_q) <<< 8) + DXW'(acrb_pkg::HALF_Q8) - DXW'(cx_q);
  assign dy  = (DXW'(cur_y_q) <<< 8) + DXW'(acrb_pkg::HALF_Q8) - DXW'(cy_q);
  assign adx = acrb_pkg::MBW'((dx < 0) ? -dx : dx);
  assign ady = acrb_pkg::MBW'((dy < 0) ? -dy : dy);

  assign d2_out = d2_q > acrb_pkg::D2W'(o2_q);
  assign d2_in  = (d2_q <= acrb_pkg::D2W'(i2_q)) || (den_q == '0);

  assign advance = (state_q == acrb_pkg::ST_P_WR) ||
                   ((state_q == acrb_pkg::ST_P_TST) && d2_out);

  assign can_load = !rsp_valid_q || rsp.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      acrb_pkg::ST_IDLE: begin
        if (accept) begin
          case (func_in)
            acrb_pkg::FUNC_CIRCLE: state_d = draw_none ? acrb_pkg::ST_DONE : acrb_pkg::ST_C_O2;
            acrb_pkg::FUNC_RECT:   state_d = draw_none ? acrb_pkg::ST_DONE : acrb_pkg::ST_P_RD;
            acrb_pkg::FUNC_WRITE:  state_d = acrb_pkg::ST_DONE;
            default:               state_d = acrb_pkg::ST_READ;
          endcase
        end
      end
      acrb_pkg::ST_READ:  state_d = acrb_pkg::ST_DONE;
      acrb_pkg::ST_C_O2:  state_d = acrb_pkg::ST_C_I2;
      acrb_pkg::ST_C_I2:  state_d = acrb_pkg::ST_C_DEN;
      acrb_pkg::ST_C_DEN: state_d = acrb_pkg::ST_P_DX;
      acrb_pkg::ST_P_DX:  state_d = acrb_pkg::ST_P_DY;
      acrb_pkg::ST_P_DY:  state_d = acrb_pkg::ST_P_D2;
      acrb_pkg::ST_P_D2:  state_d = acrb_pkg::ST_P_TST;
      acrb_pkg::ST_P_TST: begin
        if (d2_out) begin
          state_d = last_pix ? acrb_pkg::ST_DONE : acrb_pkg::ST_P_DX;
        end else if (d2_in) begin
          state_d = acrb_pkg::ST_P_WR;
        end else begin
          state_d = acrb_pkg::ST_P_NUM;
        end
      end
      acrb_pkg::ST_P_NUM: state_d = acrb_pkg::ST_P_DIV;
      acrb_pkg::ST_P_DIV: if (div_done) state_d = acrb_pkg::ST_P_WR;
      acrb_pkg::ST_P_RD:  state_d = acrb_pkg::ST_P_WR;
      acrb_pkg::ST_P_WR: begin
        if (last_pix) state_d = acrb_pkg::ST_DONE;
        else state_d = circ_q ? acrb_pkg::ST_P_DX : acrb_pkg::ST_P_RD;
      end
      acrb_pkg::ST_DONE:  if (can_load) state_d = acrb_pkg::ST_IDLE;
      default:            state_d = acrb_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready = (state_q == acrb_pkg::ST_IDLE);
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_q)
      acrb_pkg::ST_IDLE: begin
        ram_we = accept && (func_in == acrb_pkg::FUNC_WRITE) && pix_inside;
        ram_re = accept && (func_in == acrb_pkg::FUNC_READ);
      end
      acrb_pkg::ST_C_O2: begin
        mul_a = acrb_pkg::MAW'(outer_q);
        mul_b = acrb_pkg::MBW'(outer_q);
      end
      acrb_pkg::ST_C_I2: begin
        mul_a = acrb_pkg::MAW'(inner_q);
        mul_b = acrb_pkg::MBW'(inner_q);
      end
      acrb_pkg::ST_P_DX: begin
        ram_re = 1'b1;
        mul_a  = acrb_pkg::MAW'(adx);
        mul_b  = adx;
      end
      acrb_pkg::ST_P_DY: begin
        mul_a = acrb_pkg::MAW'(ady);
        mul_b = ady;
      end
      acrb_pkg::ST_P_TST: begin
        mul_a = acrb_pkg::MAW'(o2_q - acrb_pkg::O2W'(d2_q));
        mul_b = acrb_pkg::MBW'(a_q);
      end
      acrb_pkg::ST_P_NUM: div_start = 1'b1;
      acrb_pkg::ST_P_RD:  ram_re = 1'b1;
      acrb_pkg::ST_P_WR:  ram_we = (eff_q != '0);
      default: ;
    endcase
  end

  assign div_num = acrb_pkg::NW'(prod) + acrb_pkg::NW'(den_q >> 1);

  assign addr_in  = AW'(AW'(iy) * AW'(acrb_pkg::FRAME_WIDTH) + AW'(ix));
  assign addr_cur = AW'(AW'(cur_y_q) * AW'(acrb_pkg::FRAME_WIDTH) + AW'(cur_x_q));
  assign ram_addr = (state_q == acrb_pkg::ST_IDLE) ? addr_in : addr_cur;
  assign ram_wdata = (state_q == acrb_pkg::ST_IDLE) ? req.color : blend_res;

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acrb_pkg::ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == acrb_pkg::ST_DONE && can_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (state_q == acrb_pkg::ST_DONE && can_load) begin
      rsp_pix_q <= pix_q;
    end
    case (state_q)
      acrb_pkg::ST_IDLE: begin
        if (accept) begin
          cx_q    <= req.pos_x;
          cy_q    <= req.pos_y;
          outer_q <= outer_in;
          inner_q <= inner_in;
          color_q <= req.color;
          a_q     <= a_sat;
          eff_q   <= a_sat;
          x_lo_q  <= x_lo;
          x_hi_q  <= x_hi;
          y_hi_q  <= y_hi;
          cur_x_q <= x_lo;
          cur_y_q <= y_lo;
          circ_q  <= (func_in == acrb_pkg::FUNC_CIRCLE);
          rd_ok_q <= pix_inside;
          pix_q   <= '0;
        end
      end
      acrb_pkg::ST_READ:  pix_q <= rd_ok_q ? ram_rdata : '0;
      acrb_pkg::ST_C_I2:  o2_q <= prod[acrb_pkg::O2W-1:0];
      acrb_pkg::ST_C_DEN: begin
        i2_q  <= prod[acrb_pkg::O2W-1:0];
        den_q <= o2_q - prod[acrb_pkg::O2W-1:0];
      end
      acrb_pkg::ST_P_DY:  d2_q <= prod[acrb_pkg::D2W-1:0];
      acrb_pkg::ST_P_D2:  d2_q <= d2_q + prod[acrb_pkg::D2W-1:0];
      acrb_pkg::ST_P_TST: if (d2_in) eff_q <= a_q;
      acrb_pkg::ST_P_DIV: if (div_done) eff_q <= div_quo;
      default: ;
    endcase
    if (advance) begin
      if (cur_x_q == x_hi_q) begin
        cur_x_q <= x_lo_q;
        cur_y_q <= cur_y_q + 1'b1;
      end else begin
        cur_x_q <= cur_x_q + 1'b1;
      end
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.pixel_color = rsp_pix_q;
  assign rsp.finished    = 1'b1;

  // ---------------- units ----------------
  acrb_ram #(
    .WIDTH (acrb_pkg::COLOR_W),
    .DEPTH (acrb_pkg::FRAME_DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  acrb_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  acrb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  acrb_blend u_blend (
    .dst_i   (ram_rdata),
    .src_i   (color_q),
    .alpha_i (eff_q),
    .res_o   (blend_res)
  );

endmodule
